/* hdl/sdb_pkg.sv */
`timescale 1ns / 1ps
package sdb_pkg;

  localparam int CfgIdxW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RADIUS      = 8'd0,
    CFG_OPACITY     = 8'd1,
    CFG_BRUSH_COLOR = 8'd2,
    CFG_ERASE_MODE  = 8'd3
  } cfg_reg_e;

  localparam int          QBits    = 17;
  localparam logic [16:0] OneQ16   = 17'd65536;
  localparam logic [8:0]  OpMax    = 9'd256;
  localparam logic [24:0] Recip255 = 25'd16843010;

  typedef struct packed {
    logic [31:0] dst;
    logic        in_dab;
    logic [7:0]  na_erase;
  } ctx_t;

endpackage

/* hdl/soft_brush_dab_blend_unit.sv */
`timescale 1ns / 1ps
// Soft round brush dab blender. One pixel may be started on every clock; busy is
// never raised and results cannot be held off, so the consumer must take one word
// per clock. Each result strobes on done_o in the order its pixel was accepted.
// The pipeline holds the bit-serial square root (one root bit per stage, 24 +
// FRAC_BITS stages), the 17-stage distance divider and the 8-stage per-channel
// color divider. Registers may be written only while no pixel is in flight.
module soft_brush_dab_blend_unit import sdb_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [11:0]        pixel_x_i,
  input  logic [11:0]        pixel_y_i,
  input  logic [15:0]        center_x_i,
  input  logic [15:0]        center_y_i,
  input  logic [31:0]        dst_pixel_i,
  output logic               done_o,
  output logic [31:0]        new_pixel_o,
  output logic               written_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int W    = COORD_BITS + FRAC_BITS;
  localparam int RB   = 8 + FRAC_BITS;
  localparam int SB   = RB + 16;
  localparam int VB   = 2 * SB;
  localparam int RW   = SB + 2;
  localparam int S_DX = 0;
  localparam int S_SQ = 1;
  localparam int S_D2 = 2;
  localparam int S_T  = 3 + SB + QBits;
  localparam int S_T2 = S_T + 1;
  localparam int S_A  = S_T + 2;
  localparam int S_X1 = S_T + 3;
  localparam int S_SA = S_T + 4;
  localparam int S_X2 = S_T + 5;
  localparam int S_DA = S_T + 6;
  localparam int S_PR = S_T + 7;
  localparam int S_N  = S_T + 8;
  localparam int NSTG = S_N + 9;

  logic [7:0]  radius_q;
  logic [8:0]  opacity_q;
  logic [31:0] brush_color_q;
  logic        erase_mode_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q      <= 8'd8;
      opacity_q     <= 9'd256;
      brush_color_q <= 32'hFF00_0000;
      erase_mode_q  <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_RADIUS:      radius_q      <= cfg_data_i[7:0];
        CFG_OPACITY:     opacity_q     <= cfg_data_i[8:0];
        CFG_BRUSH_COLOR: brush_color_q <= cfg_data_i;
        CFG_ERASE_MODE:  erase_mode_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [RB-1:0]   rr;
  logic [2*RB-1:0] rr2_q;
  logic [8:0]      op;
  logic [7:0]      ba;

  assign rr = RB'(radius_q) << FRAC_BITS;
  assign op = (opacity_q > OpMax) ? OpMax : opacity_q;
  assign ba = brush_color_q[31:24];

  always_ff @(posedge clk_i) begin
    rr2_q <= (2*RB)'(rr) * (2*RB)'(rr);
  end

  logic       valid_q [NSTG];
  ctx_t       ctx_q   [NSTG];
  ctx_t       ctx_d   [NSTG];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NSTG; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else begin
      valid_q[0] <= start && !busy;
      for (int i = 1; i < NSTG; i++) begin
        valid_q[i] <= valid_q[i-1];
      end
    end
  end

  logic [W-1:0]     px, py, cx, cy;
  logic [W-1:0]     dx_q, dy_q;
  logic [2*W-1:0]   dx2_q, dy2_q;
  logic [2*W:0]     d2;
  logic [2*RB-1:0]  d2t_q;
  logic [16:0]      t_q, t2_q, a_q, sa_q, sa_x2_q, sa_da_q, sa_pr_q, da_q, da_pr_q;
  logic [24:0]      x1_q, x2_q;
  logic [49:0]      sa_full, da_full;
  logic [7:0]       da8_a, da8_sa;
  logic [24:0]      ps_q [3];
  logic [24:0]      pd_q [3];
  logic [25:0]      n_q  [3];
  logic [17:0]      oa_q;
  logic [QBits-1:0] dv_last;

  assign px = W'(COORD_BITS'(pixel_x_i)) << FRAC_BITS;
  assign py = W'(COORD_BITS'(pixel_y_i)) << FRAC_BITS;
  assign cx = W'(center_x_i);
  assign cy = W'(center_y_i);
  assign d2 = (2*W+1)'(dx2_q) + (2*W+1)'(dy2_q);
  assign da8_a  = ctx_q[S_A].dst[31:24];
  assign da8_sa = ctx_q[S_SA].dst[31:24];
  assign sa_full = 50'(x1_q) * 50'(Recip255);
  assign da_full = 50'(x2_q) * 50'(Recip255);

  always_comb begin
    ctx_d[0].dst      = dst_pixel_i;
    ctx_d[0].in_dab   = 1'b0;
    ctx_d[0].na_erase = 8'd0;
    for (int i = 1; i < NSTG; i++) begin
      ctx_d[i] = ctx_q[i-1];
    end
    ctx_d[S_D2].in_dab   = (rr != '0) && (d2 <= (2*W+1)'(rr2_q));
    ctx_d[S_X1].na_erase = 8'((25'(da8_a) * 25'(OneQ16 - a_q)) >> 16);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < NSTG; i++) begin
      ctx_q[i] <= ctx_d[i];
    end

    dx_q    <= (px >= cx) ? px - cx : cx - px;
    dy_q    <= (py >= cy) ? py - cy : cy - py;
    dx2_q   <= (2*W)'(dx_q) * (2*W)'(dx_q);
    dy2_q   <= (2*W)'(dy_q) * (2*W)'(dy_q);
    d2t_q   <= d2[2*RB-1:0];
    t_q     <= OneQ16 - ((dv_last > QBits'(OneQ16)) ? OneQ16 : 17'(dv_last));
    t2_q    <= 17'((34'(t_q) * 34'(t_q)) >> 16);
    a_q     <= 17'((26'(op) * 26'(t2_q)) >> 8);
    x1_q    <= 25'(a_q) * 25'(ba);
    sa_q    <= 17'(sa_full >> 32);
    x2_q    <= 25'(da8_sa) * 25'(OneQ16 - sa_q);
    sa_x2_q <= sa_q;
    da_q    <= 17'(da_full >> 32);
    sa_da_q <= sa_x2_q;
    sa_pr_q <= sa_da_q;
    da_pr_q <= da_q;
    for (int c = 0; c < 3; c++) begin
      ps_q[c] <= 25'(brush_color_q[8*c +: 8]) * 25'(sa_da_q);
      pd_q[c] <= 25'(ctx_q[S_DA].dst[8*c +: 8]) * 25'(da_q);
      n_q[c]  <= 26'(ps_q[c]) + 26'(pd_q[c]);
    end
    oa_q <= 18'(sa_pr_q) + 18'(da_pr_q);
  end

  logic [RW-1:0] sq_rem_q  [SB];
  logic [SB-1:0] sq_root_q [SB];
  logic [VB-1:0] sq_v_q    [SB];

  for (genvar k = 0; k < SB; k++) begin : g_sqrt
    logic [RW-1:0] rem_in;
    logic [SB-1:0] root_in;
    logic [VB-1:0] v_in;
    logic [RW+1:0] tmp, trial;
    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign v_in    = {d2t_q, 32'd0};
    end else begin : g_next
      assign rem_in  = sq_rem_q[k-1];
      assign root_in = sq_root_q[k-1];
      assign v_in    = sq_v_q[k-1];
    end
    assign tmp   = {rem_in, v_in[VB-1 -: 2]};
    assign trial = (RW+2)'({root_in, 2'b01});
    always_ff @(posedge clk_i) begin
      sq_v_q[k] <= v_in << 2;
      if (tmp >= trial) begin
        sq_rem_q[k]  <= RW'(tmp - trial);
        sq_root_q[k] <= {root_in[SB-2:0], 1'b1};
      end else begin
        sq_rem_q[k]  <= RW'(tmp);
        sq_root_q[k] <= {root_in[SB-2:0], 1'b0};
      end
    end
  end

  logic [RB-1:0]    dv_rem_q [QBits];
  logic [QBits-1:0] dv_quo_q [QBits];
  logic [QBits-1:0] dv_low_q [QBits];

  for (genvar j = 0; j < QBits; j++) begin : g_qdiv
    logic [RB-1:0]    rem_in;
    logic [QBits-1:0] quo_in, low_in;
    logic [RB:0]      tmp;
    if (j == 0) begin : g_first
      assign rem_in = RB'(sq_root_q[SB-1][SB-1:QBits]);
      assign quo_in = '0;
      assign low_in = sq_root_q[SB-1][QBits-1:0];
    end else begin : g_next
      assign rem_in = dv_rem_q[j-1];
      assign quo_in = dv_quo_q[j-1];
      assign low_in = dv_low_q[j-1];
    end
    assign tmp = {rem_in, low_in[QBits-1]};
    always_ff @(posedge clk_i) begin
      dv_low_q[j] <= low_in << 1;
      if (tmp >= (RB+1)'(rr)) begin
        dv_rem_q[j] <= RB'(tmp - (RB+1)'(rr));
        dv_quo_q[j] <= {quo_in[QBits-2:0], 1'b1};
      end else begin
        dv_rem_q[j] <= RB'(tmp);
        dv_quo_q[j] <= {quo_in[QBits-2:0], 1'b0};
      end
    end
  end

  assign dv_last = dv_quo_q[QBits-1];

  logic [17:0] cd_oa_q [8];

  for (genvar j = 0; j < 8; j++) begin : g_oa
    always_ff @(posedge clk_i) begin
      cd_oa_q[j] <= (j == 0) ? oa_q : cd_oa_q[(j == 0) ? 0 : j-1];
    end
  end

  logic [17:0] cd_rem_q [3][8];
  logic [7:0]  cd_quo_q [3][8];
  logic [7:0]  cd_low_q [3][8];

  for (genvar c = 0; c < 3; c++) begin : g_chan
    for (genvar j = 0; j < 8; j++) begin : g_cdiv
      logic [17:0] rem_in, oa_in;
      logic [7:0]  quo_in, low_in;
      logic [18:0] tmp;
      if (j == 0) begin : g_first
        assign rem_in = 18'(n_q[c] >> 8);
        assign quo_in = '0;
        assign low_in = n_q[c][7:0];
        assign oa_in  = oa_q;
      end else begin : g_next
        assign rem_in = cd_rem_q[c][j-1];
        assign quo_in = cd_quo_q[c][j-1];
        assign low_in = cd_low_q[c][j-1];
        assign oa_in  = cd_oa_q[j-1];
      end
      assign tmp = {rem_in, low_in[7]};
      always_ff @(posedge clk_i) begin
        cd_low_q[c][j] <= low_in << 1;
        if (tmp >= 19'(oa_in)) begin
          cd_rem_q[c][j] <= 18'(tmp - 19'(oa_in));
          cd_quo_q[c][j] <= {quo_in[6:0], 1'b1};
        end else begin
          cd_rem_q[c][j] <= 18'(tmp);
          cd_quo_q[c][j] <= {quo_in[6:0], 1'b0};
        end
      end
    end
  end

  ctx_t        ctx_l;
  logic [17:0] oa_l;
  logic [9:0]  na_p_w;
  logic [7:0]  na_p;
  logic [31:0] new_pixel_d;
  logic        written_d;

  assign ctx_l  = ctx_q[NSTG-1];
  assign oa_l   = cd_oa_q[7];
  assign na_p_w = 10'((26'(oa_l) * 26'd255) >> 16);
  assign na_p   = (na_p_w > 10'd255) ? 8'd255 : na_p_w[7:0];

  always_comb begin
    new_pixel_d = ctx_l.dst;
    written_d   = 1'b0;
    if (ctx_l.in_dab) begin
      if (erase_mode_q) begin
        new_pixel_d = {ctx_l.na_erase, ctx_l.dst[23:0]};
        written_d   = 1'b1;
      end else if (oa_l != '0) begin
        new_pixel_d = {na_p, cd_quo_q[2][7], cd_quo_q[1][7], cd_quo_q[0][7]};
        written_d   = 1'b1;
      end
    end
  end

  logic        done_q;
  logic        written_q;
  logic [31:0] new_pixel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q    <= 1'b0;
      written_q <= 1'b0;
    end else begin
      done_q    <= valid_q[NSTG-1];
      written_q <= valid_q[NSTG-1] && written_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_pixel_q <= new_pixel_d;
  end

  assign done_o      = done_q;
  assign written_o   = written_q;
  assign new_pixel_o = new_pixel_q;

  a_skip_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[NSTG-1] && !ctx_q[NSTG-1].in_dab) |=>
      (done_o && !written_o && new_pixel_o == $past(ctx_q[NSTG-1].dst)))
    else $error("skipped pixel was not passed through");

  a_written_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    written_o |-> done_o)
    else $error("written without a result strobe");

  a_ratio_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[S_T-1] && ctx_q[S_T-1].in_dab) |-> (dv_last <= QBits'(OneQ16)))
    else $error("distance ratio above one inside the dab");

  a_div_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[S_T-1] && ctx_q[S_T-1].in_dab) |-> (dv_rem_q[QBits-1] < rr))
    else $error("distance divider remainder out of range");

  a_oa_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[S_N] && ctx_q[S_N].in_dab) |-> (oa_q <= 18'(OneQ16)))
    else $error("output alpha above one");

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import sdb_pkg::*;

  localparam logic [CfgIdxW-1:0] CfgNoReg = 8'd9;
  localparam int Latency = 65;

  typedef struct {
    bit          is_cfg;
    logic [7:0]  idx;
    logic [31:0] data;
    logic [11:0] px, py;
    logic [15:0] cx, cy;
    logic [31:0] dst;
    bit          known;
    logic [31:0] want_pix;
    bit          want_wr;
  } row_t;

  typedef struct {
    logic [31:0] pix;
    bit          wr;
  } pix_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [11:0] pixel_x_i = '0, pixel_y_i = '0;
  logic [15:0] center_x_i = '0, center_y_i = '0;
  logic [31:0] dst_pixel_i = '0;
  logic done_o, written_o, cfg_ready_o;
  logic [31:0] new_pixel_o;
  logic cfg_valid_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  logic [7:0]  sh_radius = 8'd8;
  logic [8:0]  sh_opacity = 9'd256;
  logic [31:0] sh_color = 32'hFF00_0000;
  bit          sh_erase = 1'b0;

  pix_word_t pending_words[$];
  row_t      plan[$];
  int        mismatch_count = 0;
  int        words_checked = 0;
  int        written_count = 0;
  int        send_idle_pct = 0;

  always #1 clk_i = ~clk_i;

  soft_brush_dab_blend_unit u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .pixel_x_i(pixel_x_i), .pixel_y_i(pixel_y_i),
    .center_x_i(center_x_i), .center_y_i(center_y_i), .dst_pixel_i(dst_pixel_i),
    .done_o(done_o), .new_pixel_o(new_pixel_o), .written_o(written_o),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic pix_word_t blend_pixel(logic [11:0] px, logic [11:0] py,
                                            logic [15:0] cx, logic [15:0] cy,
                                            logic [31:0] dst);
    pix_word_t w;
    longint unsigned fx, fy, dx, dy, d2, rr, q, t, t2, a, op, da8, ba, sa, da, oa, c, na;
    logic [31:0] res;
    fx = longint'(px) << 4;
    fy = longint'(py) << 4;
    dx = fx >= cx ? fx - cx : cx - fx;
    dy = fy >= cy ? fy - cy : cy - fy;
    d2 = dx * dx + dy * dy;
    rr = longint'(sh_radius) << 4;
    w.pix = dst;
    w.wr = 1'b0;
    if (rr == 0 || d2 > rr * rr) return w;
    q = int_sqrt(d2 << 32) / rr;
    if (q > 65536) q = 65536;
    t = 65536 - q;
    t2 = (t * t) >> 16;
    op = sh_opacity > 256 ? 256 : sh_opacity;
    a = (op * t2) >> 8;
    da8 = dst[31:24];
    if (sh_erase) begin
      na = (da8 * (65536 - a)) >> 16;
      w.pix = {na[7:0], dst[23:0]};
      w.wr = 1'b1;
      return w;
    end
    ba = sh_color[31:24];
    sa = (a * ba) / 255;
    da = (da8 * (65536 - sa)) / 255;
    oa = sa + da;
    if (oa == 0) return w;
    res = '0;
    for (int ch = 0; ch < 3; ch++) begin
      c = (longint'(sh_color[ch*8 +: 8]) * sa + longint'(dst[ch*8 +: 8]) * da) / oa;
      if (c > 255) c = 255;
      res[ch*8 +: 8] = c[7:0];
    end
    na = (oa * 255) >> 16;
    if (na > 255) na = 255;
    res[31:24] = na[7:0];
    w.pix = res;
    w.wr = 1'b1;
    return w;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("[%0t] %s: got %h, want %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Expected words are queued when a pixel is accepted and checked in order.
  always @(posedge clk_i) begin
    pix_word_t w;
    if (rst_ni && start && !busy) pending_words.push_back(
        blend_pixel(pixel_x_i, pixel_y_i, center_x_i, center_y_i, dst_pixel_i));
    if (rst_ni && done_o) begin
      if (pending_words.size() == 0) begin
        report_mismatch("unexpected word", new_pixel_o, 32'h0);
      end else begin
        w = pending_words.pop_front();
        words_checked++;
        if (written_o) written_count++;
        if (new_pixel_o !== w.pix) report_mismatch("new_pixel", new_pixel_o, w.pix);
        if (written_o !== w.wr) report_mismatch("written", 32'(written_o), 32'(w.wr));
      end
    end
  end

  task automatic wait_drained();
    while (pending_words.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] data);
    start = 1'b0;
    wait_drained();
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_RADIUS:      sh_radius = data[7:0];
      CFG_OPACITY:     sh_opacity = data[8:0];
      CFG_BRUSH_COLOR: sh_color = data;
      CFG_ERASE_MODE:  sh_erase = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic send_pixel(logic [11:0] px, logic [11:0] py, logic [15:0] cx,
                            logic [15:0] cy, logic [31:0] dst);
    while ($urandom_range(99) < send_idle_pct) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    start = 1'b1;
    pixel_x_i = px;
    pixel_y_i = py;
    center_x_i = cx;
    center_y_i = cy;
    dst_pixel_i = dst;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  function automatic row_t item_row(logic [11:0] px, logic [11:0] py, logic [15:0] cx,
                                    logic [15:0] cy, logic [31:0] dst);
    row_t r;
    r = '{default: '0};
    r.px = px; r.py = py; r.cx = cx; r.cy = cy; r.dst = dst;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [7:0] idx, logic [31:0] data);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1; r.idx = idx; r.data = data;
    return r;
  endfunction

  function automatic row_t known_row(row_t r, logic [31:0] pix, bit wr);
    r.known = 1'b1; r.want_pix = pix; r.want_wr = wr;
    return r;
  endfunction

  task automatic random_settings();
    int sel;
    sel = $urandom_range(9);
    write_reg(CFG_RADIUS, sel == 0 ? 32'd255 : sel == 1 ? 32'd1 :
              sel == 2 ? 32'd0 : $urandom_range(2, 40));
    sel = $urandom_range(9);
    write_reg(CFG_OPACITY, sel == 0 ? 32'd0 : sel == 1 ? 32'd511 :
              sel < 5 ? 32'd256 : $urandom_range(511));
    write_reg(CFG_BRUSH_COLOR, $urandom_range(3) == 0 ? {8'hFF, 24'($urandom)} : $urandom);
    write_reg(CFG_ERASE_MODE, $urandom_range(2) == 0 ? {$urandom} : 32'd0);
  endtask

  task automatic random_pixel();
    logic [15:0] cx, cy;
    logic [31:0] dst;
    int span, ox, oy;
    cx = 16'($urandom);
    cy = 16'($urandom);
    dst = $urandom;
    if ($urandom_range(4) == 0) dst[31:24] = $urandom_range(1) ? 8'h00 : 8'hFF;
    if ($urandom_range(4) == 0) begin
      send_pixel(12'($urandom), 12'($urandom), cx, cy, dst);
    end else begin
      span = sh_radius + 1;
      ox = $urandom_range(2 * span) - span;
      oy = $urandom_range(2 * span) - span;
      send_pixel(12'((cx >> 4) + ox), 12'((cy >> 4) + oy), cx, cy, dst);
    end
  endtask

  initial begin
    row_t r;
    pix_word_t chk;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    plan.push_back(known_row(item_row(12'd100, 12'd200, 16'd1600, 16'd3200, 32'h1234_5678),
                             32'hFF00_0000, 1'b1));
    plan.push_back(known_row(item_row(12'd0, 12'd0, 16'd0, 16'd0, 32'hFFFF_FFFF),
                             32'hFF00_0000, 1'b1));
    plan.push_back(known_row(item_row(12'd500, 12'd0, 16'd0, 16'd0, 32'hA5A5_5A5A),
                             32'hA5A5_5A5A, 1'b0));
    plan.push_back(item_row(12'd4095, 12'd4095, 16'hFFFF, 16'hFFFF, 32'h0000_0000));
    plan.push_back(item_row(12'd4095, 12'd0, 16'hFFFF, 16'd0, 32'h80FF_00FF));
    plan.push_back(item_row(12'd103, 12'd204, 16'd1600, 16'd3200, 32'h40C0_8020));
    plan.push_back(item_row(12'd108, 12'd200, 16'd1600, 16'd3200, 32'h7F7F_7F7F));
    plan.push_back(cfg_row(CFG_BRUSH_COLOR, 32'h80FF_4000));
    plan.push_back(item_row(12'd105, 12'd201, 16'd1600, 16'd3200, 32'hFF00_80FF));
    plan.push_back(item_row(12'd101, 12'd200, 16'd1608, 16'd3208, 32'h0000_0000));
    plan.push_back(cfg_row(CFG_OPACITY, 32'd0));
    plan.push_back(known_row(item_row(12'd100, 12'd200, 16'd1600, 16'd3200, 32'h00AB_CDEF),
                             32'h00AB_CDEF, 1'b0));
    plan.push_back(cfg_row(CFG_OPACITY, 32'd511));
    plan.push_back(item_row(12'd102, 12'd199, 16'd1600, 16'd3200, 32'h3311_2233));
    plan.push_back(cfg_row(CFG_ERASE_MODE, 32'd1));
    plan.push_back(known_row(item_row(12'd100, 12'd200, 16'd1600, 16'd3200, 32'hFF12_3456),
                             32'h0012_3456, 1'b1));
    plan.push_back(item_row(12'd104, 12'd203, 16'd1600, 16'd3200, 32'hC012_3456));
    plan.push_back(cfg_row(CfgNoReg, 32'hFFFF_FFFF));
    plan.push_back(cfg_row(CFG_RADIUS, 32'd0));
    plan.push_back(known_row(item_row(12'd100, 12'd200, 16'd1600, 16'd3200, 32'hDEAD_BEEF),
                             32'hDEAD_BEEF, 1'b0));
    plan.push_back(cfg_row(CFG_RADIUS, 32'd255));
    plan.push_back(cfg_row(CFG_ERASE_MODE, 32'd0));
    plan.push_back(item_row(12'd300, 12'd10, 16'd1000, 16'd2000, 32'h9988_7766));
    plan.push_back(item_row(12'd0, 12'd4095, 16'd4080, 16'hFFF0, 32'h0102_0304));

    foreach (plan[i]) begin
      r = plan[i];
      if (r.is_cfg) begin
        write_reg(r.idx, r.data);
      end else begin
        send_pixel(r.px, r.py, r.cx, r.cy, r.dst);
        start = 1'b0;
        if (r.known) begin
          wait_drained();
          chk = blend_pixel(r.px, r.py, r.cx, r.cy, r.dst);
          if (chk.pix !== r.want_pix || chk.wr !== r.want_wr)
            report_mismatch("directed row", 32'(i), 32'h0);
        end
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = ph == 0 ? 35 : ph == 1 ? 50 : 0;
      for (int blk = 0; blk < 6; blk++) begin
        random_settings();
        repeat (105) random_pixel();
      end
    end
    start = 1'b0;

    wait_drained();
    repeat (Latency + 10) @(posedge clk_i);
    $display("Checked %0d output words, %0d of them written, over 18 random settings",
             words_checked, written_count);
    $display("plus directed extremes of radius, opacity, erase and paint modes.");
    if (mismatch_count == 0 && pending_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Timed out waiting for the block.");
    $display("Mismatches found");
    $finish;
  end

endmodule
